[src/bf3_pkg.sv]
package bf3_pkg;

	localparam int MAX_WIDTH_DEF  = 1024;
	localparam int PIXEL_BITS_DEF = 16;

	localparam int ROW_BITS       = 16;
	localparam int CFG_INDEX_BITS = 2;
	localparam int CFG_DATA_BITS  = 16;

	localparam int WIDTH_RESET_DEF = 1024;
	localparam logic [ROW_BITS-1:0] HEIGHT_RESET = 16'd1024;

	localparam int RECIP_SHIFT = 20;
	localparam int RECIP_BITS  = 17;
	localparam int RECIP9      = ((1 << RECIP_SHIFT) + 4) / 9;

	localparam int MAX_RES     = 4;
	localparam int QUEUE_DEPTH = 16;

	typedef logic [CFG_INDEX_BITS-1:0] cfg_index_t;

	localparam cfg_index_t REG_IMAGE_WIDTH  = 2'd0;
	localparam cfg_index_t REG_IMAGE_HEIGHT = 2'd1;

endpackage

[src/bf3_ram.sv]
module bf3_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = bf3_pkg::MAX_WIDTH_DEF,
	localparam int ADDR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic                 clk,
	input  logic                 wr_en,
	input  logic [ADDR_BITS-1:0] wr_addr,
	input  logic [WIDTH-1:0]     wr_data,
	input  logic                 rd_en,
	input  logic [ADDR_BITS-1:0] rd_addr,
	output logic [WIDTH-1:0]     rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

[src/bf3_res_fifo.sv]
module bf3_res_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = bf3_pkg::QUEUE_DEPTH,
	parameter int LANES = bf3_pkg::MAX_RES,
	localparam int PTR_BITS = $clog2(DEPTH),
	localparam int CNT_BITS = $clog2(DEPTH + 1)
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic [LANES-1:0]    push_mask,
	input  logic [WIDTH-1:0]    push_data [LANES],
	input  logic                pop,
	output logic [WIDTH-1:0]    head_data,
	output logic [CNT_BITS-1:0] count
);

	logic [WIDTH-1:0]    mem_q [DEPTH];
	logic [PTR_BITS-1:0] wr_q;
	logic [PTR_BITS-1:0] rd_q;
	logic [CNT_BITS-1:0] count_q;
	logic [PTR_BITS-1:0] slot [LANES];
	logic [CNT_BITS-1:0] n_push;

	// pack the valid lanes in order behind the tail
	always_comb begin
		logic [CNT_BITS-1:0] run;
		run = '0;
		for (int k = 0; k < LANES; k++) begin
			slot[k] = wr_q + run[PTR_BITS-1:0];
			run = run + CNT_BITS'(push_mask[k]);
		end
		n_push = run;
	end

	always_ff @(posedge clk) begin
		for (int k = 0; k < LANES; k++) begin
			if (push_mask[k]) begin
				mem_q[slot[k]] <= push_data[k];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			wr_q    <= wr_q + n_push[PTR_BITS-1:0];
			rd_q    <= rd_q + PTR_BITS'(pop);
			count_q <= count_q + n_push - CNT_BITS'(pop);
		end
	end

	assign head_data = mem_q[rd_q];
	assign count     = count_q;

endmodule

[src/box_filter_3x3_edge_replicate_unit.sv]
// 3x3 box mean filter with edge replication over a raster-order pixel stream. One pixel
// can be accepted every cycle while in_stall is low; a result reaches the output through
// the window stage, the scaling stage and the result fifo after the pixel that completes
// its window is accepted. Interior pixels give one result each, so the stream runs at one
// pixel per clock while the output side keeps up; the last column gives two and the last
// row up to four, and those leave at one per clock while out_stall is low, so in_stall rises
// whenever the 16-entry result fifo plus the two stages in flight leave less than four free
// slots. The two line stores share one RAM of MAX_WIDTH words with a registered read port.
// Configuration writes are always taken (cfg_ready is tied high) and must only be made
// between frames; there is no clearing pass after reset.
module box_filter_3x3_edge_replicate_unit #(
	parameter int MAX_WIDTH  = bf3_pkg::MAX_WIDTH_DEF,
	parameter int PIXEL_BITS = bf3_pkg::PIXEL_BITS_DEF,
	localparam int WIDTH_BITS = $clog2(MAX_WIDTH + 1),
	localparam int COL_BITS   = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [bf3_pkg::CFG_INDEX_BITS-1:0] cfg_index,
	input  logic [bf3_pkg::CFG_DATA_BITS-1:0]  cfg_data,
	input  logic                               in_valid,
	output logic                               in_stall,
	input  logic [PIXEL_BITS-1:0]              pixel_in,
	output logic                               out_valid,
	input  logic                               out_stall,
	output logic [PIXEL_BITS-1:0]              pixel_out,
	output logic [bf3_pkg::ROW_BITS-1:0]       out_row,
	output logic [COL_BITS-1:0]                out_col,
	output logic                               frame_last
);

	localparam int PB        = PIXEL_BITS;
	localparam int RB        = bf3_pkg::ROW_BITS;
	localparam int NRES      = bf3_pkg::MAX_RES;
	localparam int SUM_BITS  = PB + 4;
	localparam int PW        = SUM_BITS + bf3_pkg::RECIP_BITS;
	localparam int MEAN_BITS = PW - bf3_pkg::RECIP_SHIFT;
	localparam int EW        = 1 + COL_BITS + RB + PB;
	localparam int QCNT_BITS = $clog2(bf3_pkg::QUEUE_DEPTH + 1);
	localparam int OCC_BITS  = QCNT_BITS + 1;
	localparam int WIDTH_RESET = (bf3_pkg::WIDTH_RESET_DEF > MAX_WIDTH) ?
		MAX_WIDTH : bf3_pkg::WIDTH_RESET_DEF;
	localparam logic [PW-1:0] RECIP      = PW'(bf3_pkg::RECIP9);
	localparam logic [PW-1:0] ROUND_BIAS = PW'(1) << (bf3_pkg::RECIP_SHIFT - 1);
	localparam logic [MEAN_BITS-1:0] MEAN_MAX = MEAN_BITS'({PB{1'b1}});

	// configuration
	logic [WIDTH_BITS-1:0] image_width_q;
	logic [RB-1:0]         image_height_q;
	logic [WIDTH_BITS-1:0] w_eff;
	logic [RB-1:0]         h_eff;

	// position counters
	logic [COL_BITS-1:0]   col_q;
	logic [RB-1:0]         row_q;
	logic                  col_wrap;
	logic [RB-1:0]         row_a;
	logic                  frame_wrap;
	logic [RB-1:0]         cur_row;
	logic [COL_BITS-1:0]   cur_col;
	logic [WIDTH_BITS-1:0] col_inc;
	logic                  row_end;
	logic [RB-1:0]         row_inc;
	logic [COL_BITS-1:0]   nxt_col;
	logic [RB-1:0]         nxt_row;
	logic                  accept;

	// window stage
	logic                  valid_s1;
	logic [PB-1:0]         pix_s1;
	logic [RB-1:0]         row_s1;
	logic [COL_BITS-1:0]   col_s1;
	logic                  top_s1;
	logic                  deep_s1;
	logic                  left_s1;
	logic                  far_s1;
	logic                  lastrow_s1;
	logic                  lastcol_s1;
	logic                  fwd_s1;
	logic [2*PB-1:0]       fwd_data_s1;
	logic [2*PB-1:0]       ram_rd_data;
	logic [2*PB-1:0]       line_data;
	logic [2*PB-1:0]       line_wr_data;
	logic [PB-1:0]         cur0;
	logic [PB-1:0]         cur1;
	logic [PB-1:0]         win_q [6];
	logic [SUM_BITS-1:0]   up_cur, up_prev, up_left, up_side;
	logic [SUM_BITS-1:0]   dn_cur, dn_prev, dn_left, dn_side;
	logic [SUM_BITS-1:0]   sum_s1 [NRES];
	logic [NRES-1:0]       mask_s1;

	// scaling stage
	logic [NRES-1:0]       mask_s2;
	logic [SUM_BITS-1:0]   sum_s2 [NRES];
	logic [RB-1:0]         row_s2;
	logic [COL_BITS-1:0]   col_s2;
	logic [PB-1:0]         mean_px [NRES];
	logic [RB-1:0]         row_up;
	logic [COL_BITS-1:0]   col_lf;
	logic [EW-1:0]         push_data [NRES];

	// result fifo
	logic [EW-1:0]         head;
	logic [QCNT_BITS-1:0]  fifo_count;
	logic [OCC_BITS-1:0]   occ;
	logic                  pop;

	function automatic logic [SUM_BITS-1:0] col_up(input logic [PB-1:0] a,
		input logic [PB-1:0] b, input logic [PB-1:0] c);
		return SUM_BITS'(a) + SUM_BITS'(b) + SUM_BITS'(c);
	endfunction

	function automatic logic [SUM_BITS-1:0] col_down(input logic [PB-1:0] b,
		input logic [PB-1:0] c);
		return SUM_BITS'(b) + (SUM_BITS'(c) << 1);
	endfunction

	assign cfg_ready = 1'b1;

	always_comb begin
		if (image_width_q == '0) begin
			w_eff = WIDTH_BITS'(1);
		end else if (image_width_q > WIDTH_BITS'(MAX_WIDTH)) begin
			w_eff = WIDTH_BITS'(MAX_WIDTH);
		end else begin
			w_eff = image_width_q;
		end
		h_eff = (image_height_q == '0) ? RB'(1) : image_height_q;
	end

	// position of the incoming pixel and of the one after it
	always_comb begin
		col_wrap   = WIDTH_BITS'(col_q) >= w_eff;
		row_a      = col_wrap ? row_q + RB'(1) : row_q;
		frame_wrap = row_a >= h_eff;
		cur_row    = frame_wrap ? '0 : row_a;
		cur_col    = (frame_wrap || col_wrap) ? '0 : col_q;
		col_inc    = WIDTH_BITS'(cur_col) + WIDTH_BITS'(1);
		row_end    = col_inc >= w_eff;
		row_inc    = cur_row + RB'(1);
		nxt_col    = row_end ? '0 : col_inc[COL_BITS-1:0];
		if (row_end) begin
			nxt_row = (row_inc >= h_eff) ? '0 : row_inc;
		end else begin
			nxt_row = cur_row;
		end
	end

	assign occ      = OCC_BITS'(fifo_count) + OCC_BITS'($countones(mask_s1))
		+ OCC_BITS'($countones(mask_s2));
	assign in_stall = occ > OCC_BITS'(bf3_pkg::QUEUE_DEPTH - NRES);
	assign accept   = in_valid && !in_stall;

	bf3_ram #(
		.WIDTH (2 * PB),
		.DEPTH (MAX_WIDTH)
	) u_line_ram (
		.clk     (clk),
		.wr_en   (valid_s1),
		.wr_addr (col_s1),
		.wr_data (line_wr_data),
		.rd_en   (accept),
		.rd_addr (cur_col),
		.rd_data (ram_rd_data)
	);

	// column of three rows for the current pixel
	always_comb begin
		line_data = fwd_s1 ? fwd_data_s1 : ram_rd_data;
		cur1 = top_s1 ? line_data[PB-1:0] : pix_s1;
		if (!top_s1) begin
			cur0 = pix_s1;
		end else if (deep_s1) begin
			cur0 = line_data[2*PB-1:PB];
		end else begin
			cur0 = line_data[PB-1:0];
		end
		line_wr_data = {cur1, pix_s1};
	end

	always_comb begin
		up_cur  = col_up(cur0, cur1, pix_s1);
		up_prev = col_up(win_q[0], win_q[1], win_q[2]);
		up_left = far_s1 ? col_up(win_q[3], win_q[4], win_q[5]) : up_prev;
		up_side = left_s1 ? up_prev : up_cur;
		dn_cur  = col_down(cur1, pix_s1);
		dn_prev = col_down(win_q[1], win_q[2]);
		dn_left = far_s1 ? col_down(win_q[4], win_q[5]) : dn_prev;
		dn_side = left_s1 ? dn_prev : dn_cur;

		sum_s1[0] = up_left + up_prev + up_cur;
		sum_s1[1] = up_side + (up_cur << 1);
		sum_s1[2] = dn_left + dn_prev + dn_cur;
		sum_s1[3] = dn_side + (dn_cur << 1);

		mask_s1[0] = valid_s1 && top_s1 && left_s1;
		mask_s1[1] = valid_s1 && top_s1 && lastcol_s1;
		mask_s1[2] = valid_s1 && lastrow_s1 && left_s1;
		mask_s1[3] = valid_s1 && lastrow_s1 && lastcol_s1;
	end

	// scale by 1/9 with rounding, saturate
	always_comb begin
		logic [PW-1:0]        prod;
		logic [MEAN_BITS-1:0] mean;
		for (int k = 0; k < NRES; k++) begin
			prod = PW'(sum_s2[k]) * RECIP + ROUND_BIAS;
			mean = prod[PW-1:bf3_pkg::RECIP_SHIFT];
			mean_px[k] = (mean > MEAN_MAX) ? {PB{1'b1}} : mean[PB-1:0];
		end
		row_up = row_s2 - RB'(1);
		col_lf = col_s2 - COL_BITS'(1);
		push_data[0] = {1'b0, col_lf, row_up, mean_px[0]};
		push_data[1] = {1'b0, col_s2, row_up, mean_px[1]};
		push_data[2] = {1'b0, col_lf, row_s2, mean_px[2]};
		push_data[3] = {1'b1, col_s2, row_s2, mean_px[3]};
	end

	bf3_res_fifo #(
		.WIDTH (EW),
		.DEPTH (bf3_pkg::QUEUE_DEPTH),
		.LANES (NRES)
	) u_res_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push_mask (mask_s2),
		.push_data (push_data),
		.pop       (pop),
		.head_data (head),
		.count     (fifo_count)
	);

	assign out_valid  = fifo_count != '0;
	assign pop        = out_valid && !out_stall;
	assign pixel_out  = head[PB-1:0];
	assign out_row    = head[PB+RB-1:PB];
	assign out_col    = head[PB+RB+COL_BITS-1:PB+RB];
	assign frame_last = head[EW-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			image_width_q  <= WIDTH_BITS'(WIDTH_RESET);
			image_height_q <= bf3_pkg::HEIGHT_RESET;
			col_q          <= '0;
			row_q          <= '0;
			valid_s1       <= 1'b0;
			mask_s2        <= '0;
			for (int k = 0; k < 6; k++) begin
				win_q[k] <= '0;
			end
		end else begin
			if (cfg_valid && cfg_ready) begin
				unique case (cfg_index)
					bf3_pkg::REG_IMAGE_WIDTH: begin
						image_width_q <= cfg_data[WIDTH_BITS-1:0];
					end
					bf3_pkg::REG_IMAGE_HEIGHT: begin
						image_height_q <= cfg_data[RB-1:0];
					end
					default: begin
					end
				endcase
			end
			if (accept) begin
				col_q <= nxt_col;
				row_q <= nxt_row;
			end
			valid_s1 <= accept;
			mask_s2  <= mask_s1;
			if (valid_s1) begin
				win_q[3] <= win_q[0];
				win_q[4] <= win_q[1];
				win_q[5] <= win_q[2];
				win_q[0] <= cur0;
				win_q[1] <= cur1;
				win_q[2] <= pix_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			pix_s1      <= pixel_in;
			row_s1      <= cur_row;
			col_s1      <= cur_col;
			top_s1      <= cur_row != '0;
			deep_s1     <= cur_row >= RB'(2);
			left_s1     <= cur_col != '0;
			far_s1      <= WIDTH_BITS'(cur_col) >= WIDTH_BITS'(2);
			lastrow_s1  <= cur_row == h_eff - RB'(1);
			lastcol_s1  <= WIDTH_BITS'(cur_col) == w_eff - WIDTH_BITS'(1);
			// same column written back this edge: ram read returns the old word
			fwd_s1      <= valid_s1 && (col_s1 == cur_col);
			fwd_data_s1 <= line_wr_data;
		end
		sum_s2 <= sum_s1;
		row_s2 <= row_s1;
		col_s2 <= col_s1;
	end

endmodule
